FILE: sv/elias_delta_gap_encoder_macros.svh
// Assertion macros shared by the Elias delta gap encoder RTL.
// Depends on nothing; every use assumes clk_i and rst_ni in scope.
`ifndef ELIAS_DELTA_GAP_ENCODER_MACROS_SVH
`define ELIAS_DELTA_GAP_ENCODER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property checked on every rising edge, off while in reset
`define EDGENC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("edgenc assertion failed");
// Same-cycle implication
`define EDGENC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("edgenc implication failed");
// Next-cycle implication
`define EDGENC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("edgenc next-cycle implication failed");
`else
`define EDGENC_ASSERT(lbl, prop)
`define EDGENC_ASSERT_IMP(lbl, ante, cons)
`define EDGENC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: sv/edgenc_pkg.sv
// Types and constants of the Elias delta gap encoder.
// Used by edgenc_delta_coder and elias_delta_gap_encoder; no dependencies.
`timescale 1ns / 1ps

package edgenc_pkg;

  localparam int unsigned VALUE_W = 25;  // entry value and gap
  localparam int unsigned BLEN_W  = 5;   // bit length of a value
  localparam int unsigned NLEN_W  = 3;   // bit length of a bit length
  localparam int unsigned CODE_W  = 33;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned START_W = 18;
  localparam int unsigned ERR_W   = 2;
  localparam int unsigned RC_W    = 5;
  localparam int unsigned LIST_W  = 4;
  localparam int unsigned OBJ_W   = 20;
  localparam int unsigned RANK_W  = 4;

  localparam logic [RC_W-1:0] RC_RESET = 5'd16;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
  localparam logic [ERR_W-1:0] ERR_GAP  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL = 2'd2;

  typedef struct packed {
    logic [LIST_W-1:0] list_index;
    logic [OBJ_W-1:0]  object_number;
    logic [RANK_W-1:0] rank;
  } in_word_t;

  typedef struct packed {
    logic [CODE_W-1:0]  codeword;
    logic [LEN_W-1:0]   code_length;
    logic [START_W-1:0] start_bit;
    logic [ERR_W-1:0]   error;
  } out_word_t;

  // Coder result
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  total;
  } coder_res_t;

endpackage

FILE: sv/edgenc_delta_coder.sv
// Elias delta coder: code bits and code length of one positive number.
// Depends on edgenc_pkg.
`timescale 1ns / 1ps

module edgenc_delta_coder import edgenc_pkg::*; (
  input  logic [VALUE_W-1:0] x_i,
  output coder_res_t         res_o
);

  logic [BLEN_W-1:0] len;
  logic [NLEN_W-1:0] nlen;
  logic [BLEN_W-1:0] sh;
  logic [CODE_W-1:0] lead;
  logic [CODE_W-1:0] low;

  // Priority encoder: bit length of x
  always_comb begin
    len = '0;
    for (int i = 0; i < VALUE_W; i++) begin
      if (x_i[i]) begin
        len = BLEN_W'(i + 1);
      end
    end
  end

  // Bit length of the length
  always_comb begin
    if (len[4]) begin
      nlen = 3'd5;
    end else if (len[3]) begin
      nlen = 3'd4;
    end else if (len[2]) begin
      nlen = 3'd3;
    end else if (len[1]) begin
      nlen = 3'd2;
    end else begin
      nlen = 3'd1;
    end
  end

  // Length field then x without its leading one; leading zeros implicit
  assign sh   = len - BLEN_W'(1);
  assign lead = CODE_W'(len) << sh;
  assign low  = CODE_W'(x_i) & ~(CODE_W'(1) << sh);

  assign res_o.code  = lead | low;
  assign res_o.total = LEN_W'({nlen, 1'b0}) + LEN_W'(len) - LEN_W'(2);

endmodule

FILE: sv/elias_delta_gap_encoder.sv
// Elias delta gap encoder top level: per-list state memories, RMW pipeline.
// Depends on edgenc_pkg, edgenc_delta_coder and the assertion macro header.
//
//   channel | direction | handshake            | word
//   in      | input     | in_valid_i/in_stall_o  | in_word_t
//   out     | output    | out_valid_o/out_stall_i| out_word_t
//   cfg     | input     | cfg_we_i               | cfg_wdata_i (ref_count)
//
// One word per cycle unless the output stalls; a result is offered once its word
// has passed the coding stage and output registers (state memory read at the
// accepting edge, then code/check/write-back into the output register).
// Back-to-back words to one list are served by forwarding the write-back.
// Reset clears the per-list valid flops at once: no clearing pass.
// A stall on the output holds the coding stage and then the input.
`timescale 1ns / 1ps
`include "elias_delta_gap_encoder_macros.svh"

module elias_delta_gap_encoder import edgenc_pkg::*; #(
  parameter int unsigned NUM_LISTS   = 16,
  parameter int unsigned STREAM_BITS = 131072
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [RC_W-1:0]     cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_word_o
);

  localparam int unsigned AW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int unsigned UW = $clog2(STREAM_BITS + 1);

  // Configuration register
  logic [RC_W-1:0] ref_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_count_q <= RC_RESET;
    end else if (cfg_we_i) begin
      ref_count_q <= cfg_wdata_i;
    end
  end

  // Handshake control
  logic s1_valid_q, out_valid_q;
  logic in_acc, s1_adv, out_free, wr_en;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Input stage: entry value and address
  logic [31:0]         li_ext;
  logic                in_oor;
  logic [AW-1:0]       in_addr;
  logic [VALUE_W:0]    in_value_w;
  logic [VALUE_W-1:0]  in_value;

  assign li_ext     = 32'(in_word_i.list_index);
  assign in_oor     = li_ext >= NUM_LISTS;
  assign in_addr    = in_oor ? '0 : li_ext[AW-1:0];
  assign in_value_w = (VALUE_W + 1)'(in_word_i.object_number) * (VALUE_W + 1)'(ref_count_q)
                    + (VALUE_W + 1)'(in_word_i.rank) + (VALUE_W + 1)'(1);
  assign in_value   = in_value_w[VALUE_W-1:0];

  // State memories and per-list valid flops
  logic [VALUE_W-1:0] lv_mem_q [NUM_LISTS];
  logic [UW-1:0]      bu_mem_q [NUM_LISTS];
  logic [NUM_LISTS-1:0] vld_q;
  logic [VALUE_W-1:0] lv_rd_q;
  logic [UW-1:0]      bu_rd_q;

  // Coding stage registers
  logic [AW-1:0]      s1_addr_q;
  logic               s1_oor_q;
  logic [VALUE_W-1:0] s1_value_q;
  logic               s1_hit_q;
  logic               s1_fwd_q;
  logic [VALUE_W-1:0] s1_fwd_lv_q;
  logic [UW-1:0]      s1_fwd_bu_q;

  logic [UW-1:0]      new_used;
  logic               fwd_hit;

  assign fwd_hit = wr_en && (s1_addr_q == in_addr);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      lv_mem_q[s1_addr_q] <= s1_value_q;
      bu_mem_q[s1_addr_q] <= new_used;
    end
    if (in_acc) begin
      lv_rd_q <= lv_mem_q[in_addr];
      bu_rd_q <= bu_mem_q[in_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[s1_addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Payload of the coding stage, with write-back forwarding
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_addr_q   <= in_addr;
      s1_oor_q    <= in_oor;
      s1_value_q  <= in_value;
      s1_hit_q    <= vld_q[in_addr];
      s1_fwd_q    <= fwd_hit;
      s1_fwd_lv_q <= s1_value_q;
      s1_fwd_bu_q <= new_used;
    end
  end

  // Current list state
  logic [VALUE_W-1:0] cur_lv;
  logic [UW-1:0]      cur_bu;

  always_comb begin
    if (s1_fwd_q) begin
      cur_lv = s1_fwd_lv_q;
      cur_bu = s1_fwd_bu_q;
    end else if (s1_hit_q) begin
      cur_lv = lv_rd_q;
      cur_bu = bu_rd_q;
    end else begin
      cur_lv = '0;
      cur_bu = '0;
    end
  end

  // Gap, code and checks
  logic               empty, gap_bad, over;
  logic [VALUE_W-1:0] x;
  coder_res_t         cres;
  logic [UW:0]        sum;
  logic [ERR_W-1:0]   err;
  logic [31:0]        used_ext;
  out_word_t          res;

  assign empty   = cur_bu == '0;
  assign gap_bad = !empty && (s1_value_q <= cur_lv);
  assign x       = empty ? s1_value_q : s1_value_q - cur_lv;

  edgenc_delta_coder u_coder (
    .x_i   (x),
    .res_o (cres)
  );

  assign sum      = (UW + 1)'(cur_bu) + (UW + 1)'(cres.total);
  assign over     = sum > (UW + 1)'(STREAM_BITS);
  assign new_used = sum[UW-1:0];
  assign used_ext = 32'(cur_bu);

  always_comb begin
    if (s1_oor_q) begin
      err = ERR_FULL;
    end else if (gap_bad) begin
      err = ERR_GAP;
    end else if (over) begin
      err = ERR_FULL;
    end else begin
      err = ERR_NONE;
    end
  end

  always_comb begin
    res.error       = err;
    res.start_bit   = s1_oor_q ? '0 : used_ext[START_W-1:0];
    res.codeword    = (err == ERR_NONE) ? cres.code : '0;
    res.code_length = (err == ERR_NONE) ? cres.total : '0;
  end

  assign wr_en = s1_adv && (err == ERR_NONE);

  // Output register
  out_word_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Assertions
  `EDGENC_ASSERT_IMP(a_err_no_code, out_valid_o && (out_word_o.error != ERR_NONE), (out_word_o.code_length == '0) && (out_word_o.codeword == '0))
  `EDGENC_ASSERT_IMP(a_ok_has_len, out_valid_o && (out_word_o.error == ERR_NONE), out_word_o.code_length != '0)
  `EDGENC_ASSERT_IMP(a_wr_in_range, wr_en, !s1_oor_q && s1_valid_q)
  `EDGENC_ASSERT_IMP(a_stall_busy, in_stall_o, s1_valid_q && out_valid_q)
  `EDGENC_ASSERT_NXT(a_adv_shows, s1_adv, out_valid_o)

endmodule

FILE: test/tb_elias_delta_gap_encoder.sv
// Self-checking testbench for elias_delta_gap_encoder: random idling on both channels,
// an in-bench predictor of each list's offsets and codes, in-order word comparison.
// Depends on edgenc_pkg and the elias_delta_gap_encoder RTL.
`timescale 1ns / 1ps

module tb_elias_delta_gap_encoder;
  import edgenc_pkg::*;

  localparam int unsigned LISTS       = 16;
  localparam int unsigned STREAM_BITS = 131072;
  localparam int unsigned OBJ_MAX     = (1 << OBJ_W) - 1;
  localparam int unsigned IDLE_LIMIT  = 2000;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_we_i    = 1'b0;
  logic [RC_W-1:0] cfg_wdata_i = '0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  // Predictor state: one offset and last value per list, plus the multiplier
  logic [VALUE_W-1:0] last_val  [LISTS];
  logic [START_W-1:0] used_bits [LISTS];
  logic [RC_W-1:0]    rc_model;

  in_word_t    entry_queue[$];   // words waiting to be driven
  out_word_t   code_queue[$];    // predicted result words, oldest first
  int unsigned fail_count  = 0;
  int unsigned idle_cycles = 0;
  bit          calm        = 1'b0;
  int unsigned drv_gap = 0, drv_odds = 1, mon_gap = 0, mon_odds = 1;

  elias_delta_gap_encoder #(
    .NUM_LISTS   (LISTS),
    .STREAM_BITS (STREAM_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned bit_len(input longint unsigned v);
    int unsigned n;
    n = 0;
    while (v != 0) begin
      n++;
      v >>= 1;
    end
    return n;
  endfunction

  // Code one entry and update the list's offset and last value
  function automatic out_word_t code_entry(input in_word_t w);
    out_word_t       r;
    longint unsigned prod, code, x, len, nlen, total;
    int unsigned     li;
    logic [VALUE_W-1:0] value;
    r     = '0;
    li    = 32'(w.list_index);
    prod  = w.object_number * rc_model + w.rank + 1;
    value = prod[VALUE_W-1:0];
    r.start_bit = used_bits[li];
    if (used_bits[li] == 0) begin
      x = 64'(value);
    end else if (value <= last_val[li]) begin
      r.error = ERR_GAP;
      return r;
    end else begin
      x = 64'(value - last_val[li]);
    end
    len   = 64'(bit_len(x));
    nlen  = 64'(bit_len(len));
    total = 2 * nlen + len - 2;
    if (used_bits[li] + total > STREAM_BITS) begin
      r.error = ERR_FULL;
      return r;
    end
    // length field then the low bits of x; leading zeros are implicit
    code = (len << (len - 1)) | (x & ((64'd1 << (len - 1)) - 1));
    r.codeword    = code[CODE_W-1:0];
    r.code_length = total[LEN_W-1:0];
    last_val[li]  = value;
    used_bits[li] = used_bits[li] + total[START_W-1:0];
    return r;
  endfunction

  // Driver: predicts each accepted word, then loads the next one or idles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      drv_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) code_queue.push_back(code_entry(in_word_i));
      if (($urandom & 63) == 0) drv_odds = $urandom_range(0, 3);
      if (!in_valid_i || !in_stall_o) begin
        if (drv_gap == 0 && !calm && $urandom_range(0, 7) < drv_odds)
          drv_gap = $urandom_range(1, 9);
        if (drv_gap != 0) begin
          drv_gap--;
          in_valid_i <= 1'b0;
        end else if (entry_queue.size() != 0) begin
          in_word_i  <= entry_queue.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each accepted result word, then chooses the stall
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    out_word_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      mon_gap = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (code_queue.size() == 0) begin
          $error("result word with none predicted: %p", out_word_o);
          fail_count++;
        end else begin
          want = code_queue.pop_front();
          if (want.codeword !== out_word_o.codeword) begin
            $error("codeword: expected %0h, got %0h", want.codeword, out_word_o.codeword);
            fail_count++;
          end
          if (want.code_length !== out_word_o.code_length) begin
            $error("code_length: expected %0d, got %0d", want.code_length,
                   out_word_o.code_length);
            fail_count++;
          end
          if (want.start_bit !== out_word_o.start_bit) begin
            $error("start_bit: expected %0d, got %0d", want.start_bit, out_word_o.start_bit);
            fail_count++;
          end
          if (want.error !== out_word_o.error) begin
            $error("error: expected %0d, got %0d", want.error, out_word_o.error);
            fail_count++;
          end
        end
      end
      if (($urandom & 63) == 0) mon_odds = $urandom_range(0, 3);
      if (mon_gap == 0 && !calm && $urandom_range(0, 7) < mon_odds)
        mon_gap = $urandom_range(1, 9);
      if (mon_gap != 0) begin
        mon_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: too long without any word moving on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_entry(input int unsigned l, input int unsigned o, input int unsigned r);
    in_word_t w;
    w.list_index    = LIST_W'(l);
    w.object_number = OBJ_W'(o);
    w.rank          = RANK_W'(r);
    entry_queue.push_back(w);
  endtask

  // Wait until every word is driven and every result has come back
  task automatic settle();
    do @(negedge clk_i);
    while (entry_queue.size() != 0 || in_valid_i || code_queue.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_ref_count(input logic [RC_W-1:0] v);
    settle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    rc_model = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly rising object numbers per list, with some arbitrary words mixed in
  task automatic run_phase(input logic [RC_W-1:0] rc, input int unsigned n);
    int unsigned cursor [LISTS];
    int unsigned l, lv, step;
    write_ref_count(rc);
    for (int i = 0; i < LISTS; i++) begin
      lv = 32'(last_val[i]);
      cursor[i] = (rc == 0) ? 0 : (lv + rc - 1) / rc;
      if (cursor[i] > OBJ_MAX) cursor[i] = OBJ_MAX;
    end
    repeat (n) begin
      l = $urandom_range(0, LISTS - 1);
      if ($urandom_range(0, 6) == 0) begin
        queue_entry(l, $urandom_range(0, OBJ_MAX), $urandom_range(0, 15));
      end else begin
        case ($urandom_range(0, 9))
          0:             step = 0;
          1, 2, 3, 4:    step = $urandom_range(1, 4);
          5, 6, 7:       step = $urandom_range(1, 255);
          8:             step = $urandom_range(1, 65535);
          default:       step = $urandom_range(1, OBJ_MAX);
        endcase
        cursor[l] = (cursor[l] + step > OBJ_MAX) ? OBJ_MAX : cursor[l] + step;
        queue_entry(l, cursor[l], $urandom_range(0, 15));
      end
    end
  endtask

  initial begin
    rc_model = RC_RESET;
    for (int i = 0; i < LISTS; i++) begin
      last_val[i]  = '0;
      used_bits[i] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words at the multiplier extremes
    write_ref_count(5'd31);
    queue_entry(0, 0, 0);              // first entry, value 1
    queue_entry(0, 0, 0);              // repeated value: gap not positive
    queue_entry(0, 0, 1);              // gap of one
    queue_entry(0, OBJ_MAX, 15);       // widest gap, longest code
    queue_entry(0, 0, 0);              // value below the last one
    queue_entry(1, OBJ_MAX, 15);       // largest value as a first entry
    queue_entry(5, 12345, 7);
    queue_entry(5, 12345, 8);
    queue_entry(5, 12346, 3);
    queue_entry(10, 524288, 0);
    queue_entry(10, 699050, 10);
    write_ref_count(5'd0);
    queue_entry(3, OBJ_MAX, 0);        // multiplier zero: value is rank plus one
    queue_entry(3, 5, 15);
    queue_entry(3, 7, 15);             // same value again
    write_ref_count(5'd1);
    queue_entry(4, OBJ_MAX, 15);
    queue_entry(6, 0, 15);
    queue_entry(6, 1, 15);
    queue_entry(12, 3, 2);
    queue_entry(12, 3, 3);

    run_phase(5'd16, 80);
    run_phase(5'd1, 80);
    run_phase(RC_W'($urandom_range(2, 30)), 80);
    run_phase(5'd31, 80);
    calm = 1'b1;
    run_phase(RC_W'($urandom_range(1, 31)), 80);

    settle();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
